[hdl/dynamic_priority_scheduler_macros.svh]
// Assertion macros used by the scheduler top level.
`ifndef DYNAMIC_PRIORITY_SCHEDULER_MACROS_SVH
`define DYNAMIC_PRIORITY_SCHEDULER_MACROS_SVH

// Check that cond_a implies cond_b in the same cycle.
`define DPS_ASSERT_NOW(label, clk, rst_n, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_b)) \
        else $error("scheduler check failed: same-cycle implication");

// Check that cond_a implies cond_b in the next cycle.
`define DPS_ASSERT_NEXT(label, clk, rst_n, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_b)) \
        else $error("scheduler check failed: next-cycle implication");

`endif

[hdl/dps_pkg.sv]
// Shared constants and types of the dynamic priority scheduler.
package dps_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IDX_W  = 4;
    localparam int TIME_W = 16;
    localparam int PRIO_W = 16;

    localparam logic signed [PRIO_W-1:0] PRIO_MIN = -16'sd32767;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Slot write broadcast to every cell (load or post-run update).
    typedef struct packed {
        logic                     en;
        logic [SLOT_W-1:0]        slot;
        logic [TIME_W-1:0]        remaining;
        logic signed [PRIO_W-1:0] prio;
        logic                     active;
    } t_wr;

    // Best candidate handed from cell to cell during a scan.
    typedef struct packed {
        logic                     valid;
        logic [SLOT_W-1:0]        slot;
        logic [TIME_W-1:0]        remaining;
        logic signed [PRIO_W-1:0] prio;
    } t_best;

endpackage

[hdl/dynamic_priority_scheduler.sv]
// Top level of the dynamic priority scheduler: command handling, scan control and result word.
// A row of SLOTS identical cells holds the task table (remaining time, signed priority,
// active mark). A load word writes one slot in the cycle it is accepted and yields no
// result; a load of zero time leaves the slot inactive, a start priority of -32768 is
// stored as -32767. A tick word sends a scan token down the row: each cycle one cell
// compares its task against the best candidate handed in by its neighbor, so the winner
// (highest priority, lowest slot on ties) emerges at the end of the row and is captured.
// The update state then runs the winner one step (time and priority drop by one, priority
// floors at -32767) and registers the result word. A load leaves the block idle and ready
// for the next word; a tick takes no new word until its result is registered, the scan
// length being set by the length of the cell row. The result register frees the input
// side: a new word is accepted while the previous result still waits on the output, and
// a tick only stalls in its update step if that earlier result has not yet been taken.
`include "dynamic_priority_scheduler_macros.svh"

module dynamic_priority_scheduler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_command,
    input  logic [dps_pkg::IDX_W-1:0]         i_slot,
    input  logic [dps_pkg::TIME_W-1:0]        i_burst_time,
    input  logic signed [dps_pkg::PRIO_W-1:0] i_start_priority,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_ran_valid,
    output logic [dps_pkg::IDX_W-1:0]         o_ran_slot,
    output logic [dps_pkg::TIME_W-1:0]        o_time_left,
    output logic signed [dps_pkg::PRIO_W-1:0] o_priority_now,
    output logic                              o_finished
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    t_state r_state, n_state;

    // Candidate captured at the end of the row
    dps_pkg::t_best r_best, n_best;

    // Result word register
    logic                              r_out_valid, n_out_valid;
    logic                              r_ran_valid, n_ran_valid;
    logic [dps_pkg::IDX_W-1:0]         r_ran_slot, n_ran_slot;
    logic [dps_pkg::TIME_W-1:0]        r_time_left, n_time_left;
    logic signed [dps_pkg::PRIO_W-1:0] r_prio_now, n_prio_now;
    logic                              r_finished, n_finished;

    logic                              w_in_acc;
    logic                              w_out_free;
    logic                              w_load_ok;
    logic [dps_pkg::TIME_W-1:0]        w_run_time;
    logic signed [dps_pkg::PRIO_W-1:0] w_run_prio;
    logic signed [dps_pkg::PRIO_W-1:0] w_load_prio;
    dps_pkg::t_wr                      w_wr;

    logic [dps_pkg::SLOTS:0] w_tok;
    dps_pkg::t_best          w_best [dps_pkg::SLOTS+1];

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Launch the scan token with the tick; the row starts from an empty candidate
    assign w_tok[0]  = w_in_acc && (i_command == dps_pkg::CMD_TICK);
    assign w_best[0] = '{valid: 1'b0, slot: '0, remaining: '0, prio: '0};

    for (genvar g = 0; g < dps_pkg::SLOTS; g++) begin : g_cell
        dps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (dps_pkg::SLOT_W'(g)),
            .i_wr    (w_wr),
            .i_tok   (w_tok[g]),
            .i_best  (w_best[g]),
            .o_tok   (w_tok[g+1]),
            .o_best  (w_best[g+1])
        );
    end

    // Run the chosen task one step: drop time, drop priority down to the floor
    assign w_run_time = (r_best.remaining != '0) ? (r_best.remaining - 1'b1)
                                                 : r_best.remaining;
    assign w_run_prio = (r_best.prio > dps_pkg::PRIO_MIN)
                      ? (r_best.prio - dps_pkg::PRIO_W'(1))
                      : r_best.prio;

    // Clamp the most negative code to the floor on load
    assign w_load_prio = (i_start_priority < dps_pkg::PRIO_MIN) ? dps_pkg::PRIO_MIN
                                                                : i_start_priority;
    assign w_load_ok   = (32'(i_slot) < dps_pkg::SLOTS);

    // Slot write: a load in idle, or the write-back of the task that ran
    always_comb begin
        w_wr = '{en: 1'b0, slot: '0, remaining: '0, prio: '0, active: 1'b0};
        if (w_in_acc && (i_command == dps_pkg::CMD_LOAD) && w_load_ok) begin
            w_wr.en        = 1'b1;
            w_wr.slot      = dps_pkg::SLOT_W'(i_slot);
            w_wr.remaining = i_burst_time;
            w_wr.prio      = w_load_prio;
            w_wr.active    = (i_burst_time != '0);
        end else if ((r_state == S_UPDATE) && w_out_free && r_best.valid) begin
            w_wr.en        = 1'b1;
            w_wr.slot      = r_best.slot;
            w_wr.remaining = w_run_time;
            w_wr.prio      = w_run_prio;
            w_wr.active    = (w_run_time != '0);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_best      = r_best;
        n_out_valid = r_out_valid && !i_out_ready;
        n_ran_valid = r_ran_valid;
        n_ran_slot  = r_ran_slot;
        n_time_left = r_time_left;
        n_prio_now  = r_prio_now;
        n_finished  = r_finished;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_command == dps_pkg::CMD_TICK)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // hold the winner once the token leaves the last cell
                if (w_tok[dps_pkg::SLOTS]) begin
                    n_best  = w_best[dps_pkg::SLOTS];
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_best.valid) begin
                        n_ran_valid = 1'b1;
                        n_ran_slot  = dps_pkg::IDX_W'(r_best.slot);
                        n_time_left = w_run_time;
                        n_prio_now  = w_run_prio;
                        n_finished  = (w_run_time == '0);
                    end else begin
                        n_ran_valid = 1'b0;
                        n_ran_slot  = '0;
                        n_time_left = '0;
                        n_prio_now  = '0;
                        n_finished  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_best      <= n_best;
        r_ran_valid <= n_ran_valid;
        r_ran_slot  <= n_ran_slot;
        r_time_left <= n_time_left;
        r_prio_now  <= n_prio_now;
        r_finished  <= n_finished;
    end

    assign o_out_valid    = r_out_valid;
    assign o_ran_valid    = r_ran_valid;
    assign o_ran_slot     = r_ran_slot;
    assign o_time_left    = r_time_left;
    assign o_priority_now = r_prio_now;
    assign o_finished     = r_finished;

    // At most one scan in flight along the row
    `DPS_ASSERT_NOW(a_one_token, i_clk, i_rst_n, 1'b1, $onehot0(w_tok))
    // The token only leaves the row while a scan is pending
    `DPS_ASSERT_NOW(a_tok_in_scan, i_clk, i_rst_n, w_tok[dps_pkg::SLOTS], r_state == S_SCAN)
    // The end of the row always hands over to the update step
    `DPS_ASSERT_NEXT(a_scan_done, i_clk, i_rst_n,
        (r_state == S_SCAN) && w_tok[dps_pkg::SLOTS], r_state == S_UPDATE)
    // A finished task reports no time left
    `DPS_ASSERT_NOW(a_finish_zero, i_clk, i_rst_n,
        o_out_valid && o_finished, o_ran_valid && (o_time_left == '0))

endmodule

[hdl/dps_cell.sv]
// One task slot of the scheduler: stored task state and one compare stage.
module dps_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [dps_pkg::SLOT_W-1:0] i_idx,
    input  dps_pkg::t_wr               i_wr,
    input  logic                       i_tok,
    input  dps_pkg::t_best             i_best,
    output logic                       o_tok,
    output dps_pkg::t_best             o_best
);

    logic [dps_pkg::TIME_W-1:0]        r_rem;
    logic signed [dps_pkg::PRIO_W-1:0] r_prio;
    logic                              r_act;
    logic                              r_tok;
    dps_pkg::t_best                    r_best;
    dps_pkg::t_best                    n_best;
    logic                              w_hit;
    logic                              w_take;

    assign w_hit  = i_wr.en && (i_wr.slot == i_idx);
    // strictly greater keeps the lower slot on ties
    assign w_take = r_act && (!i_best.valid || (r_prio > i_best.prio));

    always_comb begin
        if (w_take) begin
            n_best = '{valid: 1'b1, slot: i_idx, remaining: r_rem, prio: r_prio};
        end else begin
            n_best = i_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
            if (w_hit) begin
                r_act <= i_wr.active;
            end
        end
        if (w_hit) begin
            r_rem  <= i_wr.remaining;
            r_prio <= i_wr.prio;
        end
        if (i_tok) begin
            r_best <= n_best;
        end
    end

    assign o_tok  = r_tok;
    assign o_best = r_best;

endmodule
